// File: rtl/core/owm_pkg.sv
// Package for the one-wire bus master core: command codes, queue entry types,
// slot timing constants and default sizes. No dependencies.
`default_nettype none

package owm_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // classified tick waiting for the engine
    typedef struct packed {
        logic       is_cmd;
        op_t        op;
        logic [7:0] data;
        logic       line;
    } cmd_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } result_t;

    localparam int CMD_ITEM_W = $bits(cmd_item_t);
    localparam int RESULT_W   = $bits(result_t);

    localparam int CMD_DEPTH_DEFAULT = 4;
    localparam int RES_DEPTH_DEFAULT = 4;

    localparam logic [7:0] TPU_RESET = 8'd50;

    // segment lengths in microseconds
    localparam logic [8:0] T_RST_LOW  = 9'd480;
    localparam logic [8:0] T_RST_WAIT = 9'd70;
    localparam logic [8:0] T_RST_REC  = 9'd410;
    localparam logic [8:0] T_W1_LOW   = 9'd6;
    localparam logic [8:0] T_W1_REL   = 9'd64;
    localparam logic [8:0] T_W0_LOW   = 9'd60;
    localparam logic [8:0] T_W0_REL   = 9'd10;
    localparam logic [8:0] T_RD_LOW   = 9'd6;
    localparam logic [8:0] T_RD_WAIT  = 9'd9;
    localparam logic [8:0] T_RD_REC   = 9'd55;
    localparam logic [8:0] T_UNUSED   = 9'd1;

    localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

`default_nettype wire

// File: rtl/core/one_wire_bus_master_core.sv
// One-wire bus master core, standard speed. With both queues drained, an accepted tick
// passes from the command queue to the engine, whose result is written into the result queue.
// Throughput: one tick per cycle, set by the engine advancing one tick per cycle while
// the result queue has room. Queues on both sides let input and output stall independently.
// Reset (rst_n low, async) empties both queues, idles the engine and sets
// ticks_per_microsecond to 50. Depends on owm_pkg, owm_front, owm_engine, owm_fifo.
`default_nettype none

module one_wire_bus_master_core #(
    parameter int CMD_DEPTH = owm_pkg::CMD_DEPTH_DEFAULT,
    parameter int RES_DEPTH = owm_pkg::RES_DEPTH_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] write_data,
    input  wire logic       line_sample,
    output logic            empty,
    input  wire logic       pop,
    output logic            drive_low,
    output logic            busy_res,
    output logic            done_res,
    output logic            presence,
    output logic [7:0]      read_data,
    output logic            rejected,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    import owm_pkg::*;

    logic                  cmd_valid;
    cmd_item_t             cmd_item;
    logic                  cmd_pop;
    logic                  res_full;
    logic                  res_push;
    result_t               res_in;
    logic [RESULT_W-1:0]   res_out;
    result_t               res_view;

    owm_front #(
        .DEPTH (CMD_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .write_data  (write_data),
        .line_sample (line_sample),
        .cmd_valid   (cmd_valid),
        .cmd_item    (cmd_item),
        .cmd_pop     (cmd_pop)
    );

    owm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_item  (cmd_item),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    owm_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign res_view  = result_t'(res_out);
    assign drive_low = res_view.drive_low;
    assign busy_res  = res_view.busy;
    assign done_res  = res_view.done;
    assign presence  = res_view.presence;
    assign read_data = res_view.read_data;
    assign rejected  = res_view.rejected;

endmodule

`default_nettype wire

// File: rtl/core/owm_fifo.sv
// Small register-based FIFO with count, full and empty flags.
// Standalone; used for the command queue and the result queue.
`default_nettype none

module owm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [IdxW-1:0]  wr_ptr_reg;
    logic [IdxW-1:0]  rd_ptr_reg;
    logic [CntW-1:0]  count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CntW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/owm_front.sv
// Front end: takes each tick, decodes the operation field and queues it
// for the engine. Depends on owm_pkg and owm_fifo.
`default_nettype none

module owm_front #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         operation,
    input  wire logic [7:0]         write_data,
    input  wire logic               line_sample,
    output logic                    cmd_valid,
    output owm_pkg::cmd_item_t      cmd_item,
    input  wire logic               cmd_pop
);

    import owm_pkg::*;

    cmd_item_t               in_item;
    logic [CMD_ITEM_W-1:0]   q_out;
    logic                    q_empty;

    always_comb
    begin
        in_item.op     = op_t'(operation);
        in_item.is_cmd = (op_t'(operation) != OP_TICK);
        in_item.data   = write_data;
        in_item.line   = line_sample;
    end

    owm_fifo #(
        .WIDTH (CMD_ITEM_W),
        .DEPTH (DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (in_item),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (q_out),
        .empty   (q_empty)
    );

    assign cmd_valid = !q_empty;
    assign cmd_item  = cmd_item_t'(q_out);

endmodule

`default_nettype wire

// File: rtl/core/owm_engine.sv
// Back end: bus timing engine. One queued tick per cycle advances the prescaler,
// slot sequencer and shift register when the result queue has room. Depends on owm_pkg.
`default_nettype none

module owm_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               cmd_valid,
    input  wire owm_pkg::cmd_item_t cmd_item,
    output logic                    cmd_pop,
    input  wire logic               res_full,
    output logic                    res_push,
    output owm_pkg::result_t        res_data
);

    import owm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_REC  = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_REL   = 4'd5,
        PH_RD_LOW   = 4'd6,
        PH_RD_WAIT  = 4'd7,
        PH_RD_REC   = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [8:0]  us_reg, us_next;
    logic [7:0]  pre_reg, pre_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic        presence_reg, presence_next;
    logic [7:0]  last_read_reg, last_read_next;
    logic [7:0]  tpu_reg;
    logic        done;
    logic        rej;
    logic        fire;
    logic [8:0]  seg_len;
    logic [8:0]  us_inc;

    assign cfg_ready = 1'b1;
    assign fire      = cmd_valid && !res_full;
    assign cmd_pop   = fire;
    assign res_push  = fire;
    assign us_inc    = us_reg + 9'd1;

    always_comb
    begin
        case (phase_reg)
            PH_RST_LOW:  seg_len = T_RST_LOW;
            PH_RST_WAIT: seg_len = T_RST_WAIT;
            PH_RST_REC:  seg_len = T_RST_REC;
            PH_WR_LOW:   seg_len = shift_reg[0] ? T_W1_LOW : T_W0_LOW;
            PH_WR_REL:   seg_len = shift_reg[0] ? T_W1_REL : T_W0_REL;
            PH_RD_LOW:   seg_len = T_RD_LOW;
            PH_RD_WAIT:  seg_len = T_RD_WAIT;
            PH_RD_REC:   seg_len = T_RD_REC;
            default:     seg_len = T_UNUSED;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        us_next        = us_reg;
        pre_next       = pre_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        presence_next  = presence_reg;
        last_read_next = last_read_reg;
        done           = 1'b0;
        rej            = 1'b0;

        if (phase_reg != PH_IDLE)
        begin
            rej = cmd_item.is_cmd;
            if (pre_reg == tpu_reg - 8'd1)
            begin
                pre_next = '0;
                us_next  = us_inc;
                if (us_inc >= seg_len)
                begin
                    us_next = '0;
                    case (phase_reg)
                        PH_RST_LOW:
                        begin
                            phase_next = PH_RST_WAIT;
                        end
                        PH_RST_WAIT:
                        begin
                            presence_next = !cmd_item.line;
                            phase_next    = PH_RST_REC;
                        end
                        PH_RST_REC:
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        PH_WR_LOW:
                        begin
                            phase_next = PH_WR_REL;
                        end
                        PH_WR_REL:
                        begin
                            shift_next = shift_reg >> 1;
                            if (bit_reg == LAST_BIT)
                            begin
                                bit_next   = '0;
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                bit_next   = bit_reg + 3'd1;
                                phase_next = PH_WR_LOW;
                            end
                        end
                        PH_RD_LOW:
                        begin
                            phase_next = PH_RD_WAIT;
                        end
                        PH_RD_WAIT:
                        begin
                            if (cmd_item.line)
                            begin
                                shift_next[bit_reg] = 1'b1;
                            end
                            phase_next = PH_RD_REC;
                        end
                        PH_RD_REC:
                        begin
                            if (bit_reg == LAST_BIT)
                            begin
                                bit_next       = '0;
                                last_read_next = shift_reg;
                                phase_next     = PH_IDLE;
                                done           = 1'b1;
                            end
                            else
                            begin
                                bit_next   = bit_reg + 3'd1;
                                phase_next = PH_RD_LOW;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            else
            begin
                pre_next = pre_reg + 8'd1;
            end
        end
        else if (cmd_item.is_cmd)
        begin
            us_next  = '0;
            pre_next = '0;
            bit_next = '0;
            case (cmd_item.op)
                OP_RESET:
                begin
                    presence_next = 1'b0;
                    phase_next    = PH_RST_LOW;
                end
                OP_WRITE:
                begin
                    shift_next = cmd_item.data;
                    phase_next = PH_WR_LOW;
                end
                default:
                begin
                    shift_next = '0;
                    phase_next = PH_RD_LOW;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            us_reg        <= '0;
            pre_reg       <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            presence_reg  <= 1'b0;
            last_read_reg <= '0;
            tpu_reg       <= TPU_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tpu_reg <= cfg_data;
            end
            if (fire)
            begin
                phase_reg     <= phase_next;
                us_reg        <= us_next;
                pre_reg       <= pre_next;
                bit_reg       <= bit_next;
                shift_reg     <= shift_next;
                presence_reg  <= presence_next;
                last_read_reg <= last_read_next;
            end
        end
    end

    always_comb
    begin
        res_data.drive_low = (phase_next inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW});
        res_data.busy      = (phase_next != PH_IDLE);
        res_data.done      = done;
        res_data.presence  = presence_next;
        res_data.read_data = last_read_next;
        res_data.rejected  = rej;
    end

endmodule

`default_nettype wire

// File: rtl/core/owm_checker.sv
// Port-level checks for the one-wire bus master core, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module owm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic       drive_low,
    input wire logic       busy_res,
    input wire logic       done_res,
    input wire logic       presence,
    input wire logic [7:0] read_data,
    input wire logic       rejected
);

    logic [12:0] res_word;

    assign res_word = {drive_low, busy_res, done_res, presence, read_data, rejected};

    a_flags_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}));

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown(res_word));

    // a waiting result stays put until it is popped
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(res_word)));

    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && drive_low) |-> busy_res);

    // the completing tick leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && done_res) |-> (!busy_res && !drive_low));

endmodule

bind one_wire_bus_master_core owm_checker u_owm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .drive_low (drive_low),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .presence  (presence),
    .read_data (read_data),
    .rejected  (rejected)
);

`default_nettype wire
